@@ hdl/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg: shared types for the first-fit heap allocator
// Request kinds, datapath operation codes and the command/status groups that
// run between the controller and the datapath.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES_DEF   = 65536;
  localparam int HEADER_BYTES_DEF = 32;
  localparam int ALIGN_BYTES_DEF  = 8;

  localparam int STAT_W  = 16;
  localparam int COUNT_W = 11;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_STATS   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  // header-memory write operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SETUP,
    OP_ALLOC,
    OP_SPLIT,
    OP_REL_MARK,
    OP_MERGE_NEXT,
    OP_MERGE_PREV
  } op_t;

  // header-memory read address source
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_LINK,
    RD_PREV
  } rdsel_t;

  typedef struct packed {
    logic   load;
    logic   first;
    logic   advance;
    logic   latch;
    logic   accum;
    logic   out_load;
    op_t    op;
    rdsel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  init_done;
    logic  req_bad;
    logic  fit;
    logic  split;
    logic  match;
    logic  blk_free;
    logic  last;
  } stat_t;

endpackage

@@ hdl/ffha_dp.sv @@
// ----------------------------------------------------------------------------
// ffha_dp: allocator datapath
// Header memories (size, next link, prev link, free mark), walk pointer,
// split/merge arithmetic, statistics accumulators and the output word register.
// ----------------------------------------------------------------------------
module ffha_dp #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ffha_pkg::cmd_t                      cmd,
  output ffha_pkg::stat_t                     st,
  input  logic [1:0]                          kind,
  input  logic [16:0]                         request_bytes,
  input  logic [15:0]                         payload_offset,
  output logic                                ok,
  output logic [15:0]                         granted_offset,
  output logic [ffha_pkg::STAT_W-1:0]         capacity,
  output logic [ffha_pkg::STAT_W-1:0]         used_sum,
  output logic [ffha_pkg::STAT_W-1:0]         free_sum,
  output logic [ffha_pkg::STAT_W-1:0]         max_free,
  output logic [ffha_pkg::COUNT_W-1:0]        used_count,
  output logic [ffha_pkg::COUNT_W-1:0]        free_count
);

  localparam int SLOTS     = HEAP_BYTES / ALIGN_BYTES;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int ALIGN_SH  = $clog2(ALIGN_BYTES);
  localparam int SIZE_W    = $clog2(HEAP_BYTES + 1);
  localparam int HDR_SLOTS = HEADER_BYTES / ALIGN_BYTES;
  localparam int LINK_W    = SLOT_W + 1;

  // link word: {valid, slot}
  logic [SIZE_W-1:0] size_mem [SLOTS];
  logic [LINK_W-1:0] link_mem [SLOTS];
  logic [LINK_W-1:0] back_mem [SLOTS];
  logic              free_mem [SLOTS];

  logic [SIZE_W-1:0] rd_size;
  logic [LINK_W-1:0] rd_link;
  logic [LINK_W-1:0] rd_back;
  logic              rd_free;
  logic [SLOT_W-1:0] rd_addr;

  ffha_pkg::kind_t   kind_q;
  logic [16:0]       req_q;
  logic [15:0]       pay_q;
  logic              init_q;
  logic [SLOT_W-1:0] cur;
  logic [SIZE_W-1:0] b_size;
  logic [LINK_W-1:0] b_link;
  logic [LINK_W-1:0] b_back;
  logic [SLOT_W-1:0] noff_q;

  logic                         ok_q;
  logic [15:0]                  grant_q;
  logic [ffha_pkg::STAT_W-1:0]  used_q;
  logic [ffha_pkg::STAT_W-1:0]  freeb_q;
  logic [SIZE_W-1:0]            largest_q;
  logic [ffha_pkg::COUNT_W-1:0] ucnt_q;
  logic [ffha_pkg::COUNT_W-1:0] fcnt_q;

  logic [SIZE_W-1:0] need;
  logic [SIZE_W-1:0] rest;
  logic [SLOT_W-1:0] noff;
  logic [31:0]       cur_off;
  logic              split;
  logic              mn;
  logic              mp;

  logic              size_we, link_we, back_we, free_we;
  logic [SLOT_W-1:0] size_wa, link_wa, back_wa, free_wa;
  logic [SIZE_W-1:0] size_wd;
  logic [LINK_W-1:0] link_wd, back_wd;
  logic              free_wd;

  assign need    = SIZE_W'(((32'(req_q) + 32'(ALIGN_BYTES - 1)) >> ALIGN_SH) << ALIGN_SH);
  assign rest    = rd_size - need;
  assign split   = 32'(rest) > 32'(HEADER_BYTES + ALIGN_BYTES);
  assign noff    = SLOT_W'(32'(cur) + 32'(HDR_SLOTS) + 32'(need >> ALIGN_SH));
  assign cur_off = 32'(cur) << ALIGN_SH;
  assign mn      = b_link[SLOT_W] && rd_free;
  assign mp      = b_back[SLOT_W] && rd_free;

  always_comb begin
    st.kind      = kind_q;
    st.init_done = init_q;
    st.req_bad   = (req_q == 17'd0) || (32'(req_q) > 32'(HEAP_BYTES));
    st.fit       = rd_free && (rd_size >= need);
    st.split     = split;
    st.match     = (cur_off + 32'(HEADER_BYTES)) == 32'(pay_q);
    st.blk_free  = rd_free;
    st.last      = !rd_link[SLOT_W];
  end

  always_comb begin
    case (cmd.rd_sel)
      ffha_pkg::RD_LINK: rd_addr = rd_link[SLOT_W-1:0];
      ffha_pkg::RD_PREV: rd_addr = b_back[SLOT_W-1:0];
      default:           rd_addr = '0;
    endcase
  end

  always_comb begin
    size_we = 1'b0; size_wa = cur; size_wd = '0;
    link_we = 1'b0; link_wa = cur; link_wd = '0;
    back_we = 1'b0; back_wa = cur; back_wd = '0;
    free_we = 1'b0; free_wa = cur; free_wd = 1'b0;
    unique case (cmd.op)
      ffha_pkg::OP_SETUP: begin
        size_we = 1'b1; size_wa = '0; size_wd = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
        link_we = 1'b1; link_wa = '0;
        back_we = 1'b1; back_wa = '0;
        free_we = 1'b1; free_wa = '0; free_wd = 1'b1;
      end
      ffha_pkg::OP_ALLOC: begin
        free_we = 1'b1;
        if (split) begin
          size_we = 1'b1; size_wd = need;
          link_we = 1'b1; link_wd = {1'b1, noff};
          back_we = 1'b1; back_wa = noff; back_wd = {1'b1, cur};
        end
      end
      ffha_pkg::OP_SPLIT: begin
        // tail block left over by the split
        size_we = 1'b1; size_wa = noff_q;
        size_wd = b_size - need - SIZE_W'(HEADER_BYTES);
        link_we = 1'b1; link_wa = noff_q; link_wd = b_link;
        free_we = 1'b1; free_wa = noff_q; free_wd = 1'b1;
        back_we = b_link[SLOT_W]; back_wa = b_link[SLOT_W-1:0]; back_wd = {1'b1, noff_q};
      end
      ffha_pkg::OP_REL_MARK: begin
        free_we = 1'b1; free_wd = 1'b1;
      end
      ffha_pkg::OP_MERGE_NEXT: begin
        size_we = mn; size_wd = b_size + SIZE_W'(HEADER_BYTES) + rd_size;
        link_we = mn; link_wd = rd_link;
        back_we = mn && rd_link[SLOT_W]; back_wa = rd_link[SLOT_W-1:0];
        back_wd = {1'b1, cur};
      end
      ffha_pkg::OP_MERGE_PREV: begin
        size_we = mp; size_wa = b_back[SLOT_W-1:0];
        size_wd = rd_size + SIZE_W'(HEADER_BYTES) + b_size;
        link_we = mp; link_wa = b_back[SLOT_W-1:0]; link_wd = b_link;
        back_we = mp && b_link[SLOT_W]; back_wa = b_link[SLOT_W-1:0];
        back_wd = {1'b1, b_back[SLOT_W-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (size_we) size_mem[size_wa] <= size_wd;
    rd_size <= size_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    rd_link <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (back_we) back_mem[back_wa] <= back_wd;
    rd_back <= back_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    rd_free <= free_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_q <= 1'b0;
    end else if (cmd.op == ffha_pkg::OP_SETUP) begin
      init_q <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= ffha_pkg::kind_t'(kind);
      req_q   <= request_bytes;
      pay_q   <= payload_offset;
      ok_q    <= 1'b0;
      grant_q <= '0;
      used_q  <= '0;
      freeb_q <= '0;
      largest_q <= '0;
      ucnt_q  <= '0;
      fcnt_q  <= '0;
    end else begin
      if (cmd.op == ffha_pkg::OP_ALLOC) begin
        ok_q    <= 1'b1;
        grant_q <= 16'(cur_off + 32'(HEADER_BYTES));
      end
      if (cmd.op == ffha_pkg::OP_REL_MARK) ok_q <= 1'b1;
      if (cmd.accum) begin
        if (rd_free) begin
          freeb_q <= freeb_q + ffha_pkg::STAT_W'(rd_size);
          fcnt_q  <= fcnt_q + ffha_pkg::COUNT_W'(1);
          if (rd_size > largest_q) largest_q <= rd_size;
        end else begin
          used_q <= used_q + ffha_pkg::STAT_W'(rd_size);
          ucnt_q <= ucnt_q + ffha_pkg::COUNT_W'(1);
        end
      end
    end
    if (cmd.first) cur <= '0;
    else if (cmd.advance) cur <= rd_link[SLOT_W-1:0];
    if (cmd.latch) begin
      b_size <= rd_size;
      b_link <= rd_link;
      b_back <= rd_back;
      noff_q <= noff;
    end else if (cmd.op == ffha_pkg::OP_MERGE_NEXT && mn) begin
      b_size <= b_size + SIZE_W'(HEADER_BYTES) + rd_size;
      b_link <= rd_link;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ok             <= ok_q || (kind_q == ffha_pkg::KIND_STATS);
      granted_offset <= grant_q;
      capacity       <= (kind_q == ffha_pkg::KIND_STATS) ?
                        ffha_pkg::STAT_W'(HEAP_BYTES - HEADER_BYTES) : '0;
      used_sum       <= used_q;
      free_sum       <= freeb_q;
      max_free       <= ffha_pkg::STAT_W'(largest_q);
      used_count     <= ucnt_q;
      free_count     <= fcnt_q;
    end
  end

endmodule

@@ hdl/ffha_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffha_ctrl: allocator controller
// Sequences setup, the list walk, split and merge writes, and the output word
// handshake.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ffha_pkg::stat_t st,
  output ffha_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_SPLIT,
    S_MNEXT,
    S_MPREV,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.op     = ffha_pkg::OP_NONE;
    cmd.rd_sel = ffha_pkg::RD_ZERO;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.kind == ffha_pkg::KIND_NONE) begin
          state_next = S_DONE;
        end else if (!st.init_done) begin
          cmd.op = ffha_pkg::OP_SETUP;
        end else if (st.kind == ffha_pkg::KIND_ALLOC && st.req_bad) begin
          state_next = S_DONE;
        end else begin
          cmd.first  = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.latch = 1'b1;
        unique case (st.kind)
          ffha_pkg::KIND_ALLOC: begin
            if (st.fit) begin
              cmd.op     = ffha_pkg::OP_ALLOC;
              state_next = st.split ? S_SPLIT : S_DONE;
            end else if (st.last) begin
              state_next = S_DONE;
            end else begin
              cmd.advance = 1'b1;
              cmd.rd_sel  = ffha_pkg::RD_LINK;
            end
          end
          ffha_pkg::KIND_RELEASE: begin
            if (st.match) begin
              if (!st.blk_free) begin
                cmd.op     = ffha_pkg::OP_REL_MARK;
                cmd.rd_sel = ffha_pkg::RD_LINK;
                state_next = S_MNEXT;
              end else begin
                state_next = S_DONE;
              end
            end else if (st.last) begin
              state_next = S_DONE;
            end else begin
              cmd.advance = 1'b1;
              cmd.rd_sel  = ffha_pkg::RD_LINK;
            end
          end
          ffha_pkg::KIND_STATS: begin
            cmd.accum = 1'b1;
            if (st.last) begin
              state_next = S_DONE;
            end else begin
              cmd.advance = 1'b1;
              cmd.rd_sel  = ffha_pkg::RD_LINK;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SPLIT: begin
        cmd.op     = ffha_pkg::OP_SPLIT;
        state_next = S_DONE;
      end
      S_MNEXT: begin
        cmd.op     = ffha_pkg::OP_MERGE_NEXT;
        cmd.rd_sel = ffha_pkg::RD_PREV;
        state_next = S_MPREV;
      end
      S_MPREV: begin
        cmd.op     = ffha_pkg::OP_MERGE_PREV;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

@@ hdl/first_fit_heap_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit: first-fit heap allocator with coalescing
// Address-ordered doubly linked block list kept in on-chip header memories.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word: kind (allocate, release,
//   statistics), request_bytes and payload_offset. Output channel
//   (out_valid/out_ready) returns exactly one result word per input word.
//   One request is in flight at a time; in_ready is high only when idle.
//   Sequence: a decode step that issues the first header read, then one
//   walk step per block visited on the list (one header read per cycle
//   from the header memories), then a split step, or the two merge
//   steps on a successful release, then the load of the output
//   register. Unknown kinds and rejected allocations skip the walk.
//   The next word is taken at the earliest in the cycle after the result
//   of the previous one is loaded into the output register.
//   The first request after reset (unless of an unknown kind) builds the
//   initial free block first. Statistics always walk the whole list.
//   The output register holds the result while the receiver stalls; the
//   next word can be accepted then, and its result waits until the
//   register is taken. Reset empties the heap (set up again lazily) and
//   drops any pending output; the header memories are not cleared.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   kind,
  input  logic [16:0]                  request_bytes,
  input  logic [15:0]                  payload_offset,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         ok,
  output logic [15:0]                  granted_offset,
  output logic [ffha_pkg::STAT_W-1:0]  capacity,
  output logic [ffha_pkg::STAT_W-1:0]  used_sum,
  output logic [ffha_pkg::STAT_W-1:0]  free_sum,
  output logic [ffha_pkg::STAT_W-1:0]  max_free,
  output logic [ffha_pkg::COUNT_W-1:0] used_count,
  output logic [ffha_pkg::COUNT_W-1:0] free_count
);

  ffha_pkg::cmd_t  cmd;
  ffha_pkg::stat_t st;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .kind           (kind),
    .request_bytes  (request_bytes),
    .payload_offset (payload_offset),
    .ok             (ok),
    .granted_offset (granted_offset),
    .capacity       (capacity),
    .used_sum       (used_sum),
    .free_sum       (free_sum),
    .max_free       (max_free),
    .used_count     (used_count),
    .free_count     (free_count)
  );

  // one word in flight: accepting closes the input until the result is loaded
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a request is in flight");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> granted_offset == 16'd0)
    else $error("failed request carries a granted offset");

  a_grant_no_stats: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted_offset != 16'd0 |-> ok && used_count == '0 && free_count == '0)
    else $error("grant word mixed with statistics");

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: first-fit heap allocator unit
// Drives allocate, release and statistics words through the valid/ready
// channels, tracks the heap block list in a local model and checks every
// result word against the expected one, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned HEAP  = 65536;
  localparam int unsigned HDR   = 32;
  localparam int unsigned ALIGN = 8;
  localparam int unsigned SLOTS = HEAP / ALIGN;

  typedef struct {
    int unsigned size;
    int unsigned nxt;
    int unsigned prv;
    bit          has_n;
    bit          has_p;
    bit          fr;
  } blk_t;

  typedef struct {
    logic        ok;
    logic [15:0] granted;
    logic [15:0] total;
    logic [15:0] used;
    logic [15:0] freeb;
    logic [15:0] largest;
    logic [10:0] ucnt;
    logic [10:0] fcnt;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = ffha_pkg::KIND_NONE;
  logic [16:0] request_bytes = '0;
  logic [15:0] payload_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        ok;
  logic [15:0] granted_offset, capacity, used_sum, free_sum, max_free;
  logic [10:0] used_count, free_count;

  blk_t        heap_blk[SLOTS];
  bit          heap_up;
  int unsigned live_offs[$];
  result_t     pending_results[$];
  int          err_count = 0;
  int          rx_hold = 0;
  bit          calm = 1'b0;

  first_fit_heap_allocator_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .request_bytes(request_bytes), .payload_offset(payload_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .ok(ok), .granted_offset(granted_offset), .capacity(capacity),
    .used_sum(used_sum), .free_sum(free_sum), .max_free(max_free),
    .used_count(used_count), .free_count(free_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic int unsigned slot(int unsigned off);
    return (off / ALIGN) % SLOTS;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic split_blk(int unsigned off, int unsigned want);
    int unsigned rest, noff, b, n;
    b = slot(off);
    if (want >= heap_blk[b].size) return;
    rest = heap_blk[b].size - want;
    if (rest <= HDR + ALIGN) return;
    noff = off + HDR + want;
    n = slot(noff);
    heap_blk[n].size  = rest - HDR;
    heap_blk[n].fr    = 1'b1;
    heap_blk[n].prv   = off;
    heap_blk[n].has_p = 1'b1;
    heap_blk[n].nxt   = heap_blk[b].nxt;
    heap_blk[n].has_n = heap_blk[b].has_n;
    if (heap_blk[n].has_n) heap_blk[slot(heap_blk[n].nxt)].prv = noff;
    heap_blk[b].size  = want;
    heap_blk[b].nxt   = noff;
    heap_blk[b].has_n = 1'b1;
  endtask

  task automatic coalesce(int unsigned off);
    int unsigned b, n, p;
    b = slot(off);
    if (heap_blk[b].has_n && heap_blk[slot(heap_blk[b].nxt)].fr) begin
      n = slot(heap_blk[b].nxt);
      heap_blk[b].size += HDR + heap_blk[n].size;
      heap_blk[b].nxt   = heap_blk[n].nxt;
      heap_blk[b].has_n = heap_blk[n].has_n;
      if (heap_blk[b].has_n) heap_blk[slot(heap_blk[b].nxt)].prv = off;
    end
    if (heap_blk[b].has_p && heap_blk[slot(heap_blk[b].prv)].fr) begin
      p = slot(heap_blk[b].prv);
      heap_blk[p].size += HDR + heap_blk[b].size;
      heap_blk[p].nxt   = heap_blk[b].nxt;
      heap_blk[p].has_n = heap_blk[b].has_n;
      if (heap_blk[b].has_n) heap_blk[slot(heap_blk[b].nxt)].prv = heap_blk[b].prv;
    end
  endtask

  // advance the heap model by one request and return the answer it gives
  task automatic heap_apply(input ffha_pkg::kind_t k, input int unsigned req,
                            input int unsigned pay, output result_t r);
    int unsigned cur, steps, need, b;
    int unsigned used, freeb, largest, ucnt, fcnt;
    bit more;
    r = '{default: '0};
    cur = 0; steps = 0; more = 1'b1;
    if (k == ffha_pkg::KIND_NONE) return;
    if (!heap_up) begin
      heap_blk[0] = '{size: HEAP - HDR, nxt: 0, prv: 0, has_n: 0, has_p: 0, fr: 1};
      heap_up = 1'b1;
    end
    case (k)
      ffha_pkg::KIND_ALLOC: begin
        if (req == 0 || req > HEAP) return;
        need = ((req + ALIGN - 1) / ALIGN) * ALIGN;
        while (more && steps < SLOTS) begin
          b = slot(cur);
          if (heap_blk[b].fr && heap_blk[b].size >= need) begin
            split_blk(cur, need);
            heap_blk[b].fr = 1'b0;
            r.ok = 1'b1;
            r.granted = 16'(cur + HDR);
            live_offs.push_back(cur + HDR);
            return;
          end
          more = heap_blk[b].has_n;
          cur = heap_blk[b].nxt;
          steps++;
        end
      end
      ffha_pkg::KIND_RELEASE: begin
        while (more && steps < SLOTS) begin
          b = slot(cur);
          if (cur + HDR == pay) begin
            if (!heap_blk[b].fr) begin
              heap_blk[b].fr = 1'b1;
              coalesce(cur);
              r.ok = 1'b1;
              foreach (live_offs[i])
                if (live_offs[i] == pay) begin
                  live_offs.delete(i);
                  break;
                end
            end
            return;
          end
          more = heap_blk[b].has_n;
          cur = heap_blk[b].nxt;
          steps++;
        end
      end
      default: begin
        used = 0; freeb = 0; largest = 0; ucnt = 0; fcnt = 0;
        while (more && steps < SLOTS) begin
          b = slot(cur);
          if (heap_blk[b].fr) begin
            freeb += heap_blk[b].size;
            fcnt++;
            if (heap_blk[b].size > largest) largest = heap_blk[b].size;
          end else begin
            used += heap_blk[b].size;
            ucnt++;
          end
          more = heap_blk[b].has_n;
          cur = heap_blk[b].nxt;
          steps++;
        end
        r.ok = 1'b1;
        r.total = 16'(HEAP - HDR);
        r.used = 16'(used);
        r.freeb = 16'(freeb);
        r.largest = 16'(largest);
        r.ucnt = 11'(ucnt);
        r.fcnt = 11'(fcnt);
      end
    endcase
  endtask

  // offer one word; valid stays high into the next call unless a gap is drawn
  task automatic send_word(input ffha_pkg::kind_t k, input int unsigned req,
                           input int unsigned pay);
    int g;
    result_t r;
    g = gap_len();
    repeat (g) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    kind = k;
    request_bytes = 17'(req);
    payload_offset = 16'(pay);
    do @(posedge clk); while (!in_ready);
    heap_apply(k, req, pay, r);
    pending_results.push_back(r);
  endtask

  task automatic release_live();
    int i;
    i = $urandom_range(live_offs.size() - 1);
    send_word(ffha_pkg::KIND_RELEASE, 0, live_offs[i]);
  endtask

  // receiver: random stalls plus a long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready = 1'b0;
        rx_hold--;
      end else if (calm || $urandom_range(99) < 70) begin
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b0;
        rx_hold = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        err_count++;
      end else begin
        e = pending_results.pop_front();
        if (ok !== e.ok || granted_offset !== e.granted || capacity !== e.total ||
            used_sum !== e.used || free_sum !== e.freeb ||
            max_free !== e.largest || used_count !== e.ucnt ||
            free_count !== e.fcnt) begin
          $display("%0t: mismatch expected ok=%0d off=%0d tot=%0d used=%0d free=%0d",
                   $time, e.ok, e.granted, e.total, e.used, e.freeb);
          $display("%0t:   largest=%0d ucnt=%0d fcnt=%0d", $time, e.largest, e.ucnt,
                   e.fcnt);
          $display("%0t: actual   ok=%0d off=%0d tot=%0d used=%0d free=%0d",
                   $time, ok, granted_offset, capacity, used_sum, free_sum);
          $display("%0t:   largest=%0d ucnt=%0d fcnt=%0d", $time, max_free,
                   used_count, free_count);
          err_count++;
        end
      end
    end
  end

  task automatic test_directed();
    int unsigned a, b;
    send_word(ffha_pkg::KIND_RELEASE, 0, 32);   // release before setup
    send_word(ffha_pkg::KIND_STATS, 0, 0);
    send_word(ffha_pkg::KIND_ALLOC, 0, 0);      // zero request
    send_word(ffha_pkg::KIND_ALLOC, 131071, 0);
    send_word(ffha_pkg::KIND_ALLOC, 65536, 0);  // larger than any block
    send_word(ffha_pkg::KIND_ALLOC, 65504, 0);  // whole heap, no split
    send_word(ffha_pkg::KIND_ALLOC, 1, 0);      // heap full
    send_word(ffha_pkg::KIND_STATS, 0, 0);
    send_word(ffha_pkg::KIND_RELEASE, 0, 32);
    send_word(ffha_pkg::KIND_RELEASE, 0, 32);   // double release
    send_word(ffha_pkg::KIND_NONE, 131071, 65535);
    send_word(ffha_pkg::KIND_ALLOC, 1, 0);
    a = live_offs[live_offs.size() - 1];
    send_word(ffha_pkg::KIND_ALLOC, 9, 0);
    b = live_offs[live_offs.size() - 1];
    send_word(ffha_pkg::KIND_ALLOC, 17, 0);
    send_word(ffha_pkg::KIND_RELEASE, 0, b);
    send_word(ffha_pkg::KIND_RELEASE, 0, a);    // merges with the next free block
    send_word(ffha_pkg::KIND_STATS, 0, 0);
    send_word(ffha_pkg::KIND_RELEASE, 0, 65535);
    send_word(ffha_pkg::KIND_RELEASE, 0, 0);
    send_word(ffha_pkg::KIND_ALLOC, 65449, 0);  // no free block large enough
    send_word(ffha_pkg::KIND_STATS, 0, 0);
    while (live_offs.size() > 0) release_live();
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) calm = ~calm;
      r = $urandom_range(99);
      if (live_offs.size() > 250 && r < 45) r = r + 45;
      if (r < 35)
        send_word(ffha_pkg::KIND_ALLOC, $urandom_range(256, 1), 0);
      else if (r < 42)
        send_word(ffha_pkg::KIND_ALLOC, $urandom_range(8192, 1), 0);
      else if (r < 45)
        send_word(ffha_pkg::KIND_ALLOC, $urandom_range(65536, 8192), 0);
      else if (r < 80 && live_offs.size() > 0)
        release_live();
      else if (r < 86)
        send_word(ffha_pkg::KIND_STATS, $urandom_range(131071), $urandom_range(65535));
      else if (r < 92)
        send_word(ffha_pkg::KIND_RELEASE, $urandom_range(131071), $urandom_range(65535));
      else if (r < 96)
        send_word(ffha_pkg::KIND_ALLOC,
                  ($urandom_range(1) != 0) ? 0 : $urandom_range(131071, 65537),
                  $urandom_range(65535));
      else
        send_word(ffha_pkg::KIND_NONE, $urandom_range(131071), $urandom_range(65535));
    end
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    rx_hold = 400;
    repeat (6) send_word(ffha_pkg::KIND_ALLOC, $urandom_range(64, 1), 0);
    send_word(ffha_pkg::KIND_STATS, 0, 0);
  endtask

  initial begin
    int guard;
    heap_up = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_random(1000);
    @(negedge clk);
    in_valid = 1'b0;
    guard = 0;
    while (pending_results.size() > 0 && guard < 5_000_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4000) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ first_fit_heap_allocator_unit.f @@
hdl/ffha_pkg.sv
hdl/ffha_dp.sv
hdl/ffha_ctrl.sv
hdl/first_fit_heap_allocator_unit.sv
dv/testbench.sv
